### rtl/fixed_point_q24_8_alu_core_assert.svh
// Assertion macros used by the checker of the fixed-point ALU.
// No dependencies; include by bare file name.
`ifndef FIXED_POINT_Q24_8_ALU_CORE_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define FPA_ASSERT_RST(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fixed-point ALU check failed");

// Clocked assertion that holds in and out of reset.
`define FPA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fixed-point ALU check failed");

`endif

### rtl/fpa_pkg.sv
// Package of the Q24.8 fixed-point ALU: opcodes and the word types.
// No dependencies.
package fpa_pkg;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_GT   = 4'd4;
  localparam logic [3:0] OP_LT   = 4'd5;
  localparam logic [3:0] OP_GE   = 4'd6;
  localparam logic [3:0] OP_LE   = 4'd7;
  localparam logic [3:0] OP_EQ   = 4'd8;
  localparam logic [3:0] OP_NE   = 4'd9;
  localparam logic [3:0] OP_MIN  = 4'd10;
  localparam logic [3:0] OP_MAX  = 4'd11;
  localparam logic [3:0] OP_INC  = 4'd12;
  localparam logic [3:0] OP_DEC  = 4'd13;
  localparam logic [3:0] OP_FINT = 4'd14;
  localparam logic [3:0] OP_TINT = 4'd15;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               divide_by_zero;
  } fpa_out_t;

  // Non-divide results and divide sign/flags, carried with the divider.
  typedef struct packed {
    logic        is_div;
    logic        neg;
    logic [31:0] value;
    logic        cmp;
    logic        dz;
  } fpa_side_t;

endpackage

### rtl/fpa_div.sv
// Pipelined restoring divider of the fixed-point ALU, one quotient bit per stage.
// Depends on fpa_pkg.
module fpa_div import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    i_valid,
  input  logic [32+FRAC_BITS-1:0] i_num,
  input  logic [31:0]             i_den,
  input  fpa_side_t               i_side,
  output logic                    o_valid,
  output logic [31:0]             o_quot,
  output fpa_side_t               o_side
);

  localparam int NW = 32 + FRAC_BITS;

  logic [31:0]   rem_r  [0:NW];
  logic [NW-1:0] nq_r   [0:NW];
  logic [31:0]   den_r  [0:NW];
  logic          vld_r  [0:NW];
  fpa_side_t     side_r [0:NW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= i_valid;
    end
    rem_r[0]  <= '0;
    nq_r[0]   <= i_num;
    den_r[0]  <= i_den;
    side_r[0] <= i_side;
  end

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem_r[k], nq_r[k][NW-1]};
    assign ge    = trial >= {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      rem_r[k+1]  <= ge ? 32'(trial - {1'b0, den_r[k]}) : trial[31:0];
      nq_r[k+1]   <= {nq_r[k][NW-2:0], ge};
      den_r[k+1]  <= den_r[k];
      side_r[k+1] <= side_r[k];
    end
  end

  assign o_valid = vld_r[NW];
  assign o_quot  = nq_r[NW][31:0];
  assign o_side  = side_r[NW];

endmodule

### rtl/fixed_point_q24_8_alu_core.sv
// Top level of the signed Q24.8 fixed-point ALU.
// Depends on fpa_pkg and fpa_div.
//
// One word is taken in every clock cycle; busy stays low. Each word gives
// exactly one result, shown on out_word for one cycle with out_valid high,
// once it has passed the input register, the divider stages and the output
// register, in acceptance order. The divider resolves one quotient bit per
// stage; all other operations travel beside it.
module fixed_point_q24_8_alu_core import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  fpa_in_t  in_word,
  output logic     out_valid,
  output fpa_out_t out_word
);

  localparam int NW = 32 + FRAC_BITS;

  logic    in_vld_r;
  fpa_in_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
    in_r <= in_word;
  end

  assign busy = 1'b0;

  logic signed [31:0] a, b;
  logic signed [63:0] prod;
  logic signed [NW-1:0] num;
  logic [NW-1:0] num_mag;
  logic [31:0] den_mag;
  fpa_side_t side;

  assign a    = in_r.operand_a;
  assign b    = in_r.operand_b;
  assign prod = 64'(a) * 64'(b);
  assign num  = {a, {FRAC_BITS{1'b0}}};
  assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
  assign den_mag = b[31] ? 32'(-b) : 32'(b);

  always_comb begin
    side = '0;
    side.neg = a[31] ^ b[31];
    case (in_r.opcode)
      OP_ADD:  side.value = 32'(a + b);
      OP_SUB:  side.value = 32'(a - b);
      OP_MUL:  side.value = prod[FRAC_BITS+31:FRAC_BITS];
      OP_DIV: begin
        side.is_div = (b != 0);
        side.dz     = (b == 0);
      end
      OP_GT:   side.cmp = a > b;
      OP_LT:   side.cmp = a < b;
      OP_GE:   side.cmp = a >= b;
      OP_LE:   side.cmp = a <= b;
      OP_EQ:   side.cmp = a == b;
      OP_NE:   side.cmp = a != b;
      OP_MIN:  side.value = (a < b) ? a : b;
      OP_MAX:  side.value = (a > b) ? a : b;
      OP_INC:  side.value = 32'(a + 32'sd1);
      OP_DEC:  side.value = 32'(a - 32'sd1);
      OP_FINT: side.value = 32'(a <<< FRAC_BITS);
      OP_TINT: side.value = 32'(a >>> FRAC_BITS);
      default: side = '0;
    endcase
  end

  logic        d_valid;
  logic [31:0] d_quot;
  fpa_side_t   d_side;

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (in_vld_r),
    .i_num   (num_mag),
    .i_den   (den_mag),
    .i_side  (side),
    .o_valid (d_valid),
    .o_quot  (d_quot),
    .o_side  (d_side)
  );

  logic     out_valid_r;
  fpa_out_t out_r, out_nxt;

  always_comb begin
    out_nxt.compare_true   = d_side.cmp;
    out_nxt.divide_by_zero = d_side.dz;
    if (d_side.is_div) begin
      out_nxt.result_value = d_side.neg ? 32'(-d_quot) : d_quot;
    end else begin
      out_nxt.result_value = d_side.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_valid;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

### rtl/fpa_chk.sv
// Port-level checker of the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and fixed_point_q24_8_alu_core_assert.svh.
`include "fixed_point_q24_8_alu_core_assert.svh"

module fpa_chk import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input fpa_in_t  in_word,
  input logic     out_valid,
  input fpa_out_t out_word
);

  localparam int LAT = 3 + 32 + FRAC_BITS;

  `FPA_ASSERT_ALWAYS(a_never_busy, clk, !busy)

  `FPA_ASSERT_RST(a_result_has_word, clk, rst_n, out_valid |-> $past(start, LAT))

  `FPA_ASSERT_RST(a_dz_zero, clk, rst_n, (out_valid && out_word.divide_by_zero) |-> (out_word.result_value == 0 && !out_word.compare_true))

  `FPA_ASSERT_RST(a_dz_flag, clk, rst_n, (out_valid && $past(in_word.opcode, LAT) == OP_DIV && $past(in_word.operand_b, LAT) == 0) |-> out_word.divide_by_zero)

endmodule

bind fixed_point_q24_8_alu_core fpa_chk #(.FRAC_BITS(FRAC_BITS)) u_fpa_chk (.*);
